// File: design/hcm_pkg.sv
// Shared types, codes and constant tables for the height costmap core.
// No dependencies; imported by every module of the block.
package hcm_pkg;

  // Default block parameters.
  localparam int GRID_WIDTH_DEF = 64;
  localparam int MAX_COST_DEF   = 100;
  localparam int MAX_RADIUS_DEF = 7;

  // Fixed field widths.
  localparam int COST_W  = 7;
  localparam int IDX_W   = 12;
  localparam int POS_W   = 24;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 17;
  localparam int DIV_NW  = 24;
  localparam int DIV_DW  = 13;

  // Item actions.
  localparam logic [1:0] ACT_FRAME = 2'd0;
  localparam logic [1:0] ACT_POINT = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_RES    = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_MIN_H  = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_MAX_H  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_RANGE  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_RADIUS = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_INFL   = 3'd5;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [POS_W-1:0] pos_x_mm;
    logic signed [POS_W-1:0] pos_y_mm;
    logic signed [POS_W-1:0] pos_z_mm;
    logic [IDX_W-1:0]        read_index;
  } in_t;

  typedef struct packed {
    logic [COST_W-1:0] cost_level;
    logic              accepted;
    logic [IDX_W-1:0]  cell_index;
  } out_t;

  // Divider request and response.
  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_resp_t;

  // Q1.8 gaussian weights, row is radius, column is distance.
  localparam logic [8:0] WTAB [8][8] = '{
    '{9'd256, 9'd0,   9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd256, 9'd155, 9'd0,   9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd256, 9'd199, 9'd94,  9'd0,   9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd256, 9'd217, 9'd131, 9'd57,  9'd0,  9'd0,  9'd0,  9'd0},
    '{9'd256, 9'd226, 9'd155, 9'd83,  9'd35, 9'd0,  9'd0,  9'd0},
    '{9'd256, 9'd232, 9'd172, 9'd104, 9'd52, 9'd21, 9'd0,  9'd0},
    '{9'd256, 9'd236, 9'd183, 9'd121, 9'd67, 9'd32, 9'd13, 9'd0},
    '{9'd256, 9'd238, 9'd192, 9'd135, 9'd82, 9'd43, 9'd20, 9'd8}
  };

  // Floor square root of a small value; the result stops at 7, so values
  // of 64 and above must be screened out by the caller.
  function automatic logic [2:0] isqrt_small(input logic [6:0] v);
    logic [2:0] d;
    d = 3'd0;
    for (int i = 1; i < 8; i++) begin
      if (7'(i * i) <= v) d = 3'(i);
    end
    return d;
  endfunction

endpackage

// File: design/hcm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on hcm_pkg for the request and response types.
module hcm_div
  import hcm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_resp_t resp
);

  logic              busy_r;
  logic [4:0]        cnt_r;
  logic [DIV_NW-1:0] a_r;
  logic [DIV_DW-1:0] b_r;
  logic [DIV_DW-1:0] rem_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;
  logic [DIV_DW:0]   rem_sub;

  // One shift and trial subtract per cycle.
  always_comb begin
    rem_sh  = {rem_r, a_r[DIV_NW-1]};
    ge      = rem_sh >= {1'b0, b_r};
    rem_sub = rem_sh - {1'b0, b_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= 5'(DIV_NW);
          a_r    <= req.dividend;
          b_r    <= req.divisor;
          rem_r  <= '0;
        end
      end else begin
        rem_r <= ge ? rem_sub[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
        a_r   <= {a_r[DIV_NW-2:0], ge};
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign resp.done     = done_r;
  assign resp.quotient = a_r;

endmodule

// File: design/height_costmap_with_inflation_core.sv
// Top level of the height costmap core: registers, sequencer and cost memory.
// Depends on hcm_pkg and hcm_div.
//
// Usage: an item is transferred when start is high and busy is low. Action
// new frame latches the robot pose, snaps the grid origin and clears the
// grid; add point filters a 3D point and raises its cell, then, when the
// cell rose and inflation is on, inflates the neighborhood; read cell
// returns one stored cost. Every item gives one result, shown on out_data
// for exactly one cycle with out_valid high; the receiver cannot stall and
// must take it then. Items go one at a time, with busy high meanwhile:
//   read cell        one memory read, then the result.
//   new frame        two divides for the origin, then a clear of all
//                    GRID_WIDTH^2 cells, result at the end.
//   add point        up to three divides in the shared serial divider
//                    up to the result, then inflation, one memory
//                    read-modify-write per cycle through the read and
//                    write ports of the grid memory.
// After reset the grid memory is cleared with busy high; configuration
// writes are taken at any time and apply at once.
module height_costmap_with_inflation_core
  import hcm_pkg::*;
#(
  parameter int GRID_WIDTH = GRID_WIDTH_DEF,
  parameter int MAX_COST   = MAX_COST_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_t               in_data,
  output logic              out_valid,
  output out_t              out_data,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int NCELLS = GRID_WIDTH * GRID_WIDTH;
  localparam int AW     = $clog2(NCELLS);
  localparam int CW     = $clog2(GRID_WIDTH);
  localparam int SW     = CW + 2;
  localparam int SPAN_W = $clog2(GRID_WIDTH * 1000 + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FDX  = 4'd1;
  localparam logic [3:0] S_FDY  = 4'd2;
  localparam logic [3:0] S_CLR  = 4'd3;
  localparam logic [3:0] S_PCHK = 4'd4;
  localparam logic [3:0] S_PSQ  = 4'd5;
  localparam logic [3:0] S_PDC  = 4'd6;
  localparam logic [3:0] S_PDR  = 4'd7;
  localparam logic [3:0] S_PDK  = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PWR  = 4'd10;
  localparam logic [3:0] S_SPR  = 4'd11;
  localparam logic [3:0] S_SDRN = 4'd12;
  localparam logic [3:0] S_RRD  = 4'd13;

  // Configuration registers.
  logic [9:0]  res_r;
  logic [12:0] minh_r, maxh_r;
  logic [16:0] mr_r;
  logic [2:0]  rad_r;
  logic        infl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r  <= 10'd100;
      minh_r <= 13'd100;
      maxh_r <= 13'd2000;
      mr_r   <= 17'd2800;
      rad_r  <= 3'd1;
      infl_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RES:    res_r  <= cfg_wdata[9:0];
        CFG_MIN_H:  minh_r <= cfg_wdata[12:0];
        CFG_MAX_H:  maxh_r <= cfg_wdata[12:0];
        CFG_RANGE:  mr_r   <= cfg_wdata[16:0];
        CFG_RADIUS: rad_r  <= cfg_wdata[2:0];
        CFG_INFL:   infl_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Derived configuration values.
  logic [9:0]        res_eff;
  logic [SPAN_W-1:0] span;
  logic [2:0]        r_eff;
  always_comb begin
    res_eff = (res_r == 10'd0) ? 10'd1 : res_r;
    span    = SPAN_W'(GRID_WIDTH) * SPAN_W'(res_eff);
    r_eff   = (32'(rad_r) > MAX_RADIUS) ? 3'(MAX_RADIUS) : rad_r;
  end

  // Sequencer state and datapath registers.
  logic [3:0]              state_r, state_nxt;
  logic signed [POS_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt, rz_r, rz_nxt;
  logic signed [25:0]      orgx_r, orgx_nxt, orgy_r, orgy_nxt;
  logic signed [POS_W-1:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic [DIV_NW-1:0]       ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [24:0]      dz_r, dz_nxt;
  logic [33:0]             sqx_r, sqx_nxt, sqy_r, sqy_nxt, mr2_r, mr2_nxt;
  logic [CW-1:0]           col_r, col_nxt, row_r, row_nxt;
  logic [COST_W-1:0]       cost_r, cost_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic [AW-1:0]           clr_r, clr_nxt;
  logic                    clr_emit_r, clr_emit_nxt;
  logic [IDX_W-1:0]        ridx_r, ridx_nxt;
  logic                    rok_r, rok_nxt;
  logic signed [3:0]       offx_r, offx_nxt, offy_r, offy_nxt;
  logic                    sval_r, sval_nxt;
  logic [AW-1:0]           saddr_r, saddr_nxt;
  logic [COST_W-1:0]       sv_r, sv_nxt;
  logic                    div_start_r, div_start_nxt;
  logic [DIV_NW-1:0]       div_a_r, div_a_nxt;
  logic [DIV_DW-1:0]       div_b_r, div_b_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_t                    out_data_r, out_data_nxt;

  div_req_t  div_req;
  div_resp_t div_resp;

  assign div_req.start    = div_start_r;
  assign div_req.dividend = div_a_r;
  assign div_req.divisor  = div_b_r;

  hcm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .resp (div_resp)
  );

  // Cost grid memory.
  logic [COST_W-1:0] mem [NCELLS];
  logic [COST_W-1:0] mem_rd_r;
  logic              mem_we;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [COST_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_r <= mem[mem_ra];
  end

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Origin snap from the divider quotient.
  logic               snap_neg;
  logic signed [24:0] sq;
  logic signed [35:0] snap_full;
  logic signed [25:0] org_calc;
  always_comb begin
    snap_neg  = (state_r == S_FDX) ? rx_r[POS_W-1] : ry_r[POS_W-1];
    sq        = snap_neg ? -$signed({1'b0, div_resp.quotient})
                         : $signed({1'b0, div_resp.quotient});
    snap_full = sq * $signed({1'b0, res_eff});
    org_calc  = $signed(snap_full[25:0]) - $signed(26'(span >> 1));
  end

  // Point filters.
  logic signed [26:0] ox_c, oy_c;
  logic signed [24:0] dz_c, dx_c, dy_c;
  logic [24:0]        magx, magy;
  logic               p_out, p_drop;
  always_comb begin
    ox_c   = 27'(px_r) - 27'(orgx_r);
    oy_c   = 27'(py_r) - 27'(orgy_r);
    dz_c   = 25'(pz_r) - 25'(rz_r);
    dx_c   = 25'(px_r) - 25'(rx_r);
    dy_c   = 25'(py_r) - 25'(ry_r);
    magx   = dx_c[24] ? 25'(-dx_c) : 25'(dx_c);
    magy   = dy_c[24] ? 25'(-dy_c) : 25'(dy_c);
    p_out  = ox_c[26] || oy_c[26] || (ox_c >= $signed(27'(span))) ||
             (oy_c >= $signed(27'(span)));
    p_drop = p_out || (dz_c < $signed(25'(minh_r))) ||
             (magx > 25'(mr_r)) || (magy > 25'(mr_r));
  end

  // Cell index of the point.
  logic [AW-1:0] idx_calc;
  assign idx_calc = AW'(32'(col_r) + 32'(row_r) * GRID_WIDTH);

  // Inflation cell under the current offsets. Distances of eight cells or
  // more lie beyond every radius.
  logic signed [SW-1:0] sx, sy;
  logic [2:0]           ax, ay;
  logic [6:0]           dsq;
  logic [2:0]           dd;
  logic                 s_ok;
  logic [15:0]          wprod;
  logic [AW-1:0]        saddr_calc;
  always_comb begin
    sx         = $signed({2'b00, col_r}) + SW'(offx_r);
    sy         = $signed({2'b00, row_r}) + SW'(offy_r);
    ax         = offx_r[3] ? 3'(-offx_r) : offx_r[2:0];
    ay         = offy_r[3] ? 3'(-offy_r) : offy_r[2:0];
    dsq        = 7'(ax) * 7'(ax) + 7'(ay) * 7'(ay);
    dd         = isqrt_small(dsq);
    s_ok       = !sx[SW-1] && !sy[SW-1] &&
                 (sx < $signed(SW'(GRID_WIDTH))) && (sy < $signed(SW'(GRID_WIDTH))) &&
                 (dsq < 7'd64) && (dd <= r_eff);
    wprod      = 16'(WTAB[r_eff][dd]) * 16'(cost_r);
    saddr_calc = AW'(32'(sx[SW-2:0]) + 32'(sy[SW-2:0]) * GRID_WIDTH);
  end

  // Memory port selection.
  always_comb begin
    mem_we = 1'b0;
    mem_wa = saddr_r;
    mem_wd = sv_r;
    case (state_r)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      S_PWR: begin
        mem_we = cost_r > mem_rd_r;
        mem_wa = idx_r;
        mem_wd = cost_r;
      end
      default: mem_we = sval_r && (sv_r > mem_rd_r);
    endcase
    case (state_r)
      S_PRD:   mem_ra = idx_calc;
      S_SPR:   mem_ra = saddr_calc;
      default: mem_ra = AW'(in_data.read_index);
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    rz_nxt        = rz_r;
    orgx_nxt      = orgx_r;
    orgy_nxt      = orgy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    dz_nxt        = dz_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    mr2_nxt       = mr2_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cost_nxt      = cost_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    clr_emit_nxt  = clr_emit_r;
    ridx_nxt      = ridx_r;
    rok_nxt       = rok_r;
    offx_nxt      = offx_r;
    offy_nxt      = offy_r;
    sval_nxt      = 1'b0;
    saddr_nxt     = saddr_r;
    sv_nxt        = sv_r;
    div_start_nxt = 1'b0;
    div_a_nxt     = div_a_r;
    div_b_nxt     = div_b_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          px_nxt = in_data.pos_x_mm;
          py_nxt = in_data.pos_y_mm;
          pz_nxt = in_data.pos_z_mm;
          unique case (in_data.action)
            ACT_FRAME: begin
              rx_nxt        = in_data.pos_x_mm;
              ry_nxt        = in_data.pos_y_mm;
              rz_nxt        = in_data.pos_z_mm;
              div_start_nxt = 1'b1;
              div_a_nxt     = in_data.pos_x_mm[POS_W-1] ? 24'(-in_data.pos_x_mm)
                                                        : in_data.pos_x_mm;
              div_b_nxt     = 13'(res_eff);
              state_nxt     = S_FDX;
            end
            ACT_POINT: state_nxt = S_PCHK;
            ACT_READ: begin
              ridx_nxt  = in_data.read_index;
              rok_nxt   = 32'(in_data.read_index) < NCELLS;
              state_nxt = S_RRD;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_FDX: begin
        if (div_resp.done) begin
          orgx_nxt      = org_calc;
          div_start_nxt = 1'b1;
          div_a_nxt     = ry_r[POS_W-1] ? 24'(-ry_r) : ry_r;
          state_nxt     = S_FDY;
        end
      end
      S_FDY: begin
        if (div_resp.done) begin
          orgy_nxt     = org_calc;
          clr_nxt      = '0;
          clr_emit_nxt = 1'b1;
          state_nxt    = S_CLR;
        end
      end
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NCELLS - 1)) begin
          out_valid_nxt = clr_emit_r;
          state_nxt     = S_IDLE;
        end
      end
      S_PCHK: begin
        if (p_drop) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ox_nxt    = 24'(ox_c);
          oy_nxt    = 24'(oy_c);
          dz_nxt    = dz_c;
          sqx_nxt   = magx[16:0] * magx[16:0];
          sqy_nxt   = magy[16:0] * magy[16:0];
          mr2_nxt   = mr_r * mr_r;
          state_nxt = S_PSQ;
        end
      end
      S_PSQ: begin
        if ((35'(sqx_r) + 35'(sqy_r)) > 35'(mr2_r)) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          div_start_nxt = 1'b1;
          div_a_nxt     = ox_r;
          div_b_nxt     = 13'(res_eff);
          state_nxt     = S_PDC;
        end
      end
      S_PDC: begin
        if (div_resp.done) begin
          col_nxt       = CW'(div_resp.quotient);
          div_start_nxt = 1'b1;
          div_a_nxt     = oy_r;
          state_nxt     = S_PDR;
        end
      end
      S_PDR: begin
        if (div_resp.done) begin
          row_nxt = CW'(div_resp.quotient);
          if ((dz_r > $signed(25'(maxh_r))) || (maxh_r <= minh_r)) begin
            cost_nxt  = COST_W'(MAX_COST);
            state_nxt = S_PRD;
          end else begin
            div_start_nxt = 1'b1;
            div_a_nxt     = 24'((dz_r[12:0] - minh_r) * 20'(MAX_COST));
            div_b_nxt     = maxh_r - minh_r;
            state_nxt     = S_PDK;
          end
        end
      end
      S_PDK: begin
        if (div_resp.done) begin
          cost_nxt  = COST_W'(div_resp.quotient);
          state_nxt = S_PRD;
        end
      end
      S_PRD: begin
        idx_nxt   = idx_calc;
        state_nxt = S_PWR;
      end
      S_PWR: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.accepted   = 1'b1;
        out_data_nxt.cell_index = IDX_W'(idx_r);
        out_data_nxt.cost_level = (cost_r > mem_rd_r) ? cost_r : mem_rd_r;
        if ((cost_r > mem_rd_r) && infl_r && (r_eff != 3'd0)) begin
          offx_nxt  = -$signed({1'b0, r_eff});
          offy_nxt  = -$signed({1'b0, r_eff});
          state_nxt = S_SPR;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SPR: begin
        sval_nxt  = s_ok;
        saddr_nxt = saddr_calc;
        sv_nxt    = wprod[14:8];
        if (offy_r == $signed({1'b0, r_eff})) begin
          offy_nxt = -$signed({1'b0, r_eff});
          offx_nxt = offx_r + 4'sd1;
          if (offx_r == $signed({1'b0, r_eff})) state_nxt = S_SDRN;
        end else begin
          offy_nxt = offy_r + 4'sd1;
        end
      end
      S_SDRN: state_nxt = S_IDLE;
      S_RRD: begin
        out_valid_nxt           = 1'b1;
        out_data_nxt.cell_index = ridx_r;
        out_data_nxt.cost_level = rok_r ? mem_rd_r : '0;
        state_nxt               = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers, reset into the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      sval_r      <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      rx_r        <= '0;
      ry_r        <= '0;
      rz_r        <= '0;
      orgx_r      <= '0;
      orgy_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      sval_r      <= sval_nxt;
      div_start_r <= div_start_nxt;
      out_valid_r <= out_valid_nxt;
      rx_r        <= rx_nxt;
      ry_r        <= ry_nxt;
      rz_r        <= rz_nxt;
      orgx_r      <= orgx_nxt;
      orgy_r      <= orgy_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
    dz_r       <= dz_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    mr2_r      <= mr2_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    cost_r     <= cost_nxt;
    idx_r      <= idx_nxt;
    ridx_r     <= ridx_nxt;
    rok_r      <= rok_nxt;
    offx_r     <= offx_nxt;
    offy_r     <= offy_nxt;
    saddr_r    <= saddr_nxt;
    sv_r       <= sv_nxt;
    div_a_r    <= div_a_nxt;
    div_b_r    <= div_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/hcm_checker.sv
// Port-level checks for the height costmap core, bound to the top level.
// Depends on hcm_pkg for the item types and action codes.
module hcm_checker
  import hcm_pkg::*;
#(
  parameter int MAX_COST = MAX_COST_DEF
) (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input in_t               in_data,
  input logic              out_valid,
  input out_t              out_data,
  input logic              cfg_we,
  input logic [CFG_IW-1:0] cfg_index,
  input logic [CFG_DW-1:0] cfg_wdata
);

  // The grid is cleared after reset before any item is taken.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> busy)
    else $error("busy low right after reset");

  // No cost ever exceeds the saturation value.
  a_cost_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.cost_level) <= MAX_COST))
    else $error("cell cost above saturation");

  // A read transfer returns its own index, with accepted low.
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.action == ACT_READ) |->
      ##2 (out_valid && !out_data.accepted &&
           out_data.cell_index == $past(in_data.read_index, 2)))
    else $error("read result missing or wrong index");

  // Configuration is written only while the core is idle, to a known register.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (!busy && cfg_index <= CFG_INFL && !$isunknown(cfg_wdata)))
    else $error("configuration write while busy or to an unknown register");

endmodule

bind height_costmap_with_inflation_core hcm_checker #(.MAX_COST(MAX_COST)) u_hcm_checker (.*);
